// ===== rtl/core/sbm_pkg.sv =====
// shared types and constants for the smbus bit-bang master
package sbm_pkg;

  localparam int unsigned TIMER_BITS_DEF = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned CNT_W          = 4;

  localparam logic [CFG_W-1:0] CFG_RST_TICKS = 16'd5;

  // request modes
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUS_FREE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW      = 2'd2;

  typedef enum logic [7:0] {
    PH_IDLE = 8'b0000_0001,
    PH_1    = 8'b0000_0010,
    PH_2    = 8'b0000_0100,
    PH_3    = 8'b0000_1000,
    PH_4    = 8'b0001_0000,
    PH_5    = 8'b0010_0000,
    PH_6    = 8'b0100_0000,
    PH_7    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] write_byte;
    logic       master_ack;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       slave_ack;
    logic       rejected;
  } out_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage

// ===== rtl/core/sbm_engine.sv =====
// pin sequencer: config registers, phase state and the per-request update
module sbm_engine #(
  parameter int unsigned TIMER_BITS = sbm_pkg::TIMER_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  sbm_pkg::in_t    req,
  input  sbm_pkg::cfg_wr_t cfg,
  output sbm_pkg::out_t   res
);

  localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

  function automatic logic [TIMER_BITS-1:0] sat_load(input logic [sbm_pkg::CFG_W-1:0] v);
    logic [32:0] w;
    w = {17'd0, v};
    if (w == 33'd0) w = 33'd1;
    if (w > TMAX) w = TMAX;
    return w[TIMER_BITS-1:0];
  endfunction

  logic [sbm_pkg::CFG_W-1:0] bus_free_r, high_r, low_r;

  sbm_pkg::phase_t         phase_r, phase_nxt, go_ph;
  logic [2:0]              cmd_r, cmd_nxt;
  logic [sbm_pkg::CNT_W-1:0] bit_r, bit_nxt, bit_inc;
  logic [7:0]              shift_r, shift_nxt;
  logic [TIMER_BITS-1:0]   timer_r, timer_nxt, timer_dec;
  logic                    scl_r, scl_nxt, sda_r, sda_nxt;
  logic                    ackd_r, ackd_nxt, acks_r, acks_nxt;
  logic [7:0]              hold_r, hold_nxt;
  logic                    go, done, rej, busy, is_cmd, is_start;
  logic [TIMER_BITS-1:0]   ld_bf, ld_hi, ld_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_free_r <= sbm_pkg::CFG_RST_TICKS;
      high_r     <= sbm_pkg::CFG_RST_TICKS;
      low_r      <= sbm_pkg::CFG_RST_TICKS;
    end else if (cfg.we) begin
      if (cfg.index == sbm_pkg::REG_BUS_FREE) bus_free_r <= cfg.data;
      if (cfg.index == sbm_pkg::REG_HIGH)     high_r     <= cfg.data;
      if (cfg.index == sbm_pkg::REG_LOW)      low_r      <= cfg.data;
    end
  end

  assign ld_bf = sat_load(bus_free_r);
  assign ld_hi = sat_load(high_r);
  assign ld_lo = sat_load(low_r);

  assign busy      = (phase_r != sbm_pkg::PH_IDLE);
  assign is_cmd    = (req.mode >= sbm_pkg::MODE_START) && (req.mode <= sbm_pkg::MODE_READ);
  assign timer_dec = timer_r - TIMER_BITS'(timer_r != '0);
  assign bit_inc   = bit_r + sbm_pkg::CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    timer_nxt = timer_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ackd_nxt  = ackd_r;
    acks_nxt  = acks_r;
    hold_nxt  = hold_r;
    go        = 1'b0;
    go_ph     = sbm_pkg::PH_1;
    done      = 1'b0;
    rej       = 1'b0;
    is_start  = 1'b0;

    if (is_cmd) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        cmd_nxt = req.mode;
        bit_nxt = '0;
        if (req.mode == sbm_pkg::MODE_WRITE) shift_nxt = req.write_byte;
        if (req.mode == sbm_pkg::MODE_READ) begin
          shift_nxt = 8'h00;
          ackd_nxt  = req.master_ack;
        end
        go    = 1'b1;
        go_ph = sbm_pkg::PH_1;
      end
    end else if (busy) begin
      timer_nxt = timer_dec;
      if (timer_dec == '0) begin
        if (cmd_r == sbm_pkg::MODE_START || cmd_r == sbm_pkg::MODE_STOP) begin
          unique case (phase_r)
            sbm_pkg::PH_1: begin go = 1'b1; go_ph = sbm_pkg::PH_2; end
            sbm_pkg::PH_2: begin go = 1'b1; go_ph = sbm_pkg::PH_3; end
            sbm_pkg::PH_3: begin go = 1'b1; go_ph = sbm_pkg::PH_4; end
            default:       done = 1'b1;
          endcase
        end else if (cmd_r == sbm_pkg::MODE_WRITE) begin
          unique case (phase_r)
            sbm_pkg::PH_1: begin go = 1'b1; go_ph = sbm_pkg::PH_2; end
            sbm_pkg::PH_2: begin go = 1'b1; go_ph = sbm_pkg::PH_3; end
            sbm_pkg::PH_3: begin
              bit_nxt = bit_inc;
              go      = 1'b1;
              go_ph   = (bit_inc < sbm_pkg::CNT_W'(sbm_pkg::BYTE_BITS)) ?
                        sbm_pkg::PH_1 : sbm_pkg::PH_4;
            end
            sbm_pkg::PH_4: begin go = 1'b1; go_ph = sbm_pkg::PH_5; end
            default: begin
              acks_nxt = req.sda_in;
              scl_nxt  = 1'b0;
              done     = 1'b1;
            end
          endcase
        end else if (cmd_r == sbm_pkg::MODE_READ) begin
          unique case (phase_r)
            sbm_pkg::PH_1: begin go = 1'b1; go_ph = sbm_pkg::PH_2; end
            sbm_pkg::PH_2: begin
              shift_nxt = {shift_r[6:0], req.sda_in};
              go        = 1'b1;
              go_ph     = sbm_pkg::PH_3;
            end
            sbm_pkg::PH_3: begin go = 1'b1; go_ph = sbm_pkg::PH_4; end
            sbm_pkg::PH_4: begin
              bit_nxt = bit_inc;
              go      = 1'b1;
              go_ph   = (bit_inc < sbm_pkg::CNT_W'(sbm_pkg::BYTE_BITS)) ?
                        sbm_pkg::PH_2 : sbm_pkg::PH_5;
            end
            sbm_pkg::PH_5: begin go = 1'b1; go_ph = sbm_pkg::PH_6; end
            sbm_pkg::PH_6: begin go = 1'b1; go_ph = sbm_pkg::PH_7; end
            default: begin
              hold_nxt = shift_r;
              done     = 1'b1;
            end
          endcase
        end else begin
          phase_nxt = sbm_pkg::PH_IDLE;
        end
      end
    end

    if (done) begin
      phase_nxt = sbm_pkg::PH_IDLE;
      timer_nxt = '0;
    end

    // open the next phase: drive its pin, where it has one, and load its duration
    if (go) begin
      phase_nxt = go_ph;
      if (cmd_nxt == sbm_pkg::MODE_START || cmd_nxt == sbm_pkg::MODE_STOP) begin
        is_start = (cmd_nxt == sbm_pkg::MODE_START);
        unique case (go_ph)
          sbm_pkg::PH_1: if (is_start) sda_nxt = 1'b1; else scl_nxt = 1'b0;
          sbm_pkg::PH_2: if (is_start) scl_nxt = 1'b1; else sda_nxt = 1'b0;
          sbm_pkg::PH_3: if (is_start) sda_nxt = 1'b0; else scl_nxt = 1'b1;
          default:       if (is_start) scl_nxt = 1'b0; else sda_nxt = 1'b1;
        endcase
        timer_nxt = ld_bf;
      end else if (cmd_nxt == sbm_pkg::MODE_WRITE) begin
        unique case (go_ph)
          sbm_pkg::PH_1: begin
            sda_nxt   = shift_nxt[7];
            shift_nxt = {shift_nxt[6:0], 1'b0};
            timer_nxt = ld_bf;
          end
          sbm_pkg::PH_2: begin scl_nxt = 1'b1; timer_nxt = ld_hi; end
          sbm_pkg::PH_3: begin scl_nxt = 1'b0; timer_nxt = ld_lo; end
          sbm_pkg::PH_4: begin sda_nxt = 1'b1; timer_nxt = ld_hi; end
          default:       begin scl_nxt = 1'b1; timer_nxt = ld_hi; end
        endcase
      end else begin
        unique case (go_ph)
          sbm_pkg::PH_1: begin sda_nxt = 1'b1;     timer_nxt = ld_hi; end
          sbm_pkg::PH_2: begin scl_nxt = 1'b1;     timer_nxt = ld_hi; end
          sbm_pkg::PH_3: begin                     timer_nxt = ld_lo; end
          sbm_pkg::PH_4: begin scl_nxt = 1'b0;     timer_nxt = ld_lo; end
          sbm_pkg::PH_5: begin sda_nxt = ackd_nxt; timer_nxt = ld_bf; end
          sbm_pkg::PH_6: begin scl_nxt = 1'b1;     timer_nxt = ld_hi; end
          default:       begin scl_nxt = 1'b0;     timer_nxt = ld_lo; end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sbm_pkg::PH_IDLE;
      cmd_r   <= sbm_pkg::MODE_TICK;
      bit_r   <= '0;
      shift_r <= 8'h00;
      timer_r <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ackd_r  <= 1'b1;
      acks_r  <= 1'b1;
      hold_r  <= 8'h00;
    end else if (step) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      timer_r <= timer_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ackd_r  <= ackd_nxt;
      acks_r  <= acks_nxt;
      hold_r  <= hold_nxt;
    end
  end

  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.busy_res  = (phase_nxt != sbm_pkg::PH_IDLE);
    res.done_res  = done;
    res.read_data = hold_nxt;
    res.slave_ack = acks_nxt;
    res.rejected  = rej;
  end

endmodule

// ===== rtl/core/smbus_bitbang_master.sv =====
// top level of the smbus bit-bang master: request handshake and result register
// a request's result is registered and presented in the cycle after it is accepted
// throughput: one request per cycle; in_ready drops only while a result waits
// the pin engine updates its state in the accept cycle, the result register
// decouples it from the consumer
// reset (synchronous, rst_n low): bus released, engine idle, timings back to 5 ticks
module smbus_bitbang_master #(
  parameter int unsigned TIMER_BITS = sbm_pkg::TIMER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sbm_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sbm_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [sbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbm_pkg::CFG_W-1:0]         cfg_wdata
);

  logic             accept;
  sbm_pkg::out_t    res;
  sbm_pkg::cfg_wr_t cfg;
  logic             out_valid_r;
  sbm_pkg::out_t    out_data_r;

  // a new request enters whenever the result slot is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // configuration writes go straight to the engine, no handshake
  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  sbm_engine #(
    .TIMER_BITS(TIMER_BITS)
  ) u_engine (
    .clk  (clk),
    .rst_n(rst_n),
    .step (accept),
    .req  (in_data),
    .cfg  (cfg),
    .res  (res)
  );

  // result register: one entry, refilled in the same cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/sbm_checker.sv =====
// port-level checks for the smbus bit-bang master, bound to the top level
module sbm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input sbm_pkg::out_t out_data
);

  // a request on offer stays on offer until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("request withdrawn before acceptance");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an empty result slot never blocks a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked with empty result slot");

  // a finished request leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res && !out_data.rejected)
    else $error("done flagged while busy or rejected");

  // a request is rejected only while another one is still running
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rejected |-> out_data.busy_res)
    else $error("request rejected while idle");

endmodule

bind smbus_bitbang_master sbm_checker u_sbm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
